// File: src/battery_trimmed_mean_filter_top_assert.svh
// Assertion macros shared by the filter modules.
`ifndef BATTERY_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH
`define BATTERY_TRIMMED_MEAN_FILTER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define BTMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BTMF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/btmf_pkg.sv
`default_nettype none
package btmf_pkg;

  localparam int RAW_W = 12;
  localparam int MV_W = 14;
  localparam int SCALE_SHIFT = 12;
  localparam int PROD_W = RAW_W + MV_W;
  localparam logic [MV_W-1:0] SCALE_NUM = 14'd10800;
  localparam logic [MV_W-1:0] LOW_RESET = 14'd3000;
  localparam logic [MV_W-1:0] HIGH_RESET = 14'd4300;
  localparam int MIN_TRIM_COUNT = 3;
  localparam int DEF_WINDOW_SIZE = 5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;

  typedef struct packed {
    logic take;
    logic mul;
    logic push;
    logic acc;
    logic trim;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic acc_last;
    logic div_last;
    logic short_win;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: src/battery_trimmed_mean_filter_top.sv
// Battery voltage filter with a trimmed mean over the last WINDOW_SIZE samples.
// The input channel carries one raw 12-bit converter word per transfer; it is
// scaled to millivolts and pushed into the sample window.
// The output channel returns one word per input: the filtered voltage and a
// flag that is set when it lies strictly between the two limit registers.
// The configuration channel writes the low limit at index 0 and the high
// limit at index 1; other indexes are ignored. It is always ready.
// One word is processed at a time. A word goes through the multiply, the
// push, a pass over the held samples for sum, minimum and maximum, the trim,
// and the restoring divider, which works through the 14 + clog2(WINDOW_SIZE)
// dividend bits, and is then loaded into the output register.
// While fewer than three samples are held the divider is skipped.
// The next input is accepted once the result sits in the output register.
// If the receiver stalls, the result waits there and the next word finishes
// its computation, then holds until the output register is free.
// Reset empties the window and loads the limits with 3000 and 4300 mV.
`default_nettype none
module battery_trimmed_mean_filter_top
  import btmf_pkg::*;
#(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [RAW_W-1:0]     raw_sample_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [MV_W-1:0]           voltage_mv_o,
  output logic                      in_range_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MV_W-1:0]      cfg_data_i
);

  logic [MV_W-1:0] low_limit_q, high_limit_q;
  cmd_t            cmd;
  status_t         status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q <= LOW_RESET;
      high_limit_q <= HIGH_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_LOW_LIMIT) begin
        low_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == REG_HIGH_LIMIT) begin
        high_limit_q <= cfg_data_i;
      end
    end
  end

  btmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  btmf_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .raw_sample_i (raw_sample_i),
    .low_limit_i  (low_limit_q),
    .high_limit_i (high_limit_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .voltage_mv_o (voltage_mv_o),
    .in_range_o   (in_range_o)
  );

endmodule
`default_nettype wire

// File: src/btmf_ctrl.sv
`default_nettype none
`include "battery_trimmed_mean_filter_top_assert.svh"
module btmf_ctrl
  import btmf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_PUSH = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_TRIM = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.acc_last) begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        cmd_o.trim = 1'b1;
        state_d = status_i.short_win ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `BTMF_ASSERT(a_take_starts_mul, (in_valid_i && in_ready_o) |=> (state_q == ST_MUL), "accepted word did not start the multiply")
  `BTMF_ASSERT(a_no_load_when_busy, status_i.out_busy |-> !cmd_o.out_load, "result loaded over a word not yet taken")

endmodule
`default_nettype wire

// File: src/btmf_datapath.sv
`default_nettype none
`include "battery_trimmed_mean_filter_top_assert.svh"
module btmf_datapath
  import btmf_pkg::*;
#(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cmd_t            cmd_i,
  output status_t              status_o,
  input  wire logic [RAW_W-1:0] raw_sample_i,
  input  wire logic [MV_W-1:0] low_limit_i,
  input  wire logic [MV_W-1:0] high_limit_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [MV_W-1:0]      voltage_mv_o,
  output logic                 in_range_o
);

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int IDX_W = $clog2(WINDOW_SIZE);
  localparam int SUM_W = MV_W + $clog2(WINDOW_SIZE);
  localparam int BIT_W = $clog2(SUM_W);

  logic [RAW_W-1:0]  raw_q;
  logic [PROD_W-1:0] prod_q;
  logic [MV_W-1:0]   win_q [WINDOW_SIZE];
  logic [CNT_W-1:0]  fill_q;
  logic [IDX_W-1:0]  idx_q;
  logic [SUM_W-1:0]  sum_q;
  logic [MV_W-1:0]   lo_q, hi_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [CNT_W-1:0]  rem_q;
  logic [BIT_W-1:0]  bit_q;
  logic              out_valid_q;

  logic [MV_W-1:0]   acc_sample;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_trial;
  logic              q_bit;
  logic              short_win;
  logic [MV_W-1:0]   result;

  assign acc_sample = win_q[idx_q];
  assign divisor = fill_q - CNT_W'(2);
  assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
  assign rem_trial = rem_shift - {1'b0, divisor};
  assign q_bit = (rem_shift >= {1'b0, divisor});
  assign short_win = (fill_q < CNT_W'(MIN_TRIM_COUNT));
  assign result = short_win ? win_q[0] : dvd_q[MV_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      raw_q <= raw_sample_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(raw_q) * PROD_W'(SCALE_NUM);
    end
    if (cmd_i.push) begin
      win_q[0] <= prod_q[SCALE_SHIFT +: MV_W];
      for (int i = 1; i < WINDOW_SIZE; i++) begin
        win_q[i] <= win_q[i-1];
      end
      idx_q <= '0;
      sum_q <= '0;
      lo_q <= '1;
      hi_q <= '0;
    end
    if (cmd_i.acc) begin
      idx_q <= idx_q + IDX_W'(1);
      sum_q <= sum_q + SUM_W'(acc_sample);
      if (acc_sample < lo_q) begin
        lo_q <= acc_sample;
      end
      if (acc_sample > hi_q) begin
        hi_q <= acc_sample;
      end
    end
    if (cmd_i.trim) begin
      dvd_q <= sum_q - SUM_W'(lo_q) - SUM_W'(hi_q);
      rem_q <= '0;
      bit_q <= BIT_W'(SUM_W - 1);
    end
    if (cmd_i.div) begin
      dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
      rem_q <= q_bit ? rem_trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
      bit_q <= bit_q - BIT_W'(1);
    end
    if (cmd_i.out_load) begin
      voltage_mv_o <= result;
      in_range_o <= (result > low_limit_i) && (result < high_limit_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push && (fill_q != CNT_W'(WINDOW_SIZE))) begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o.acc_last = (idx_q == IDX_W'(fill_q - CNT_W'(1)));
  assign status_o.div_last = (bit_q == '0);
  assign status_o.short_win = short_win;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  `BTMF_ASSERT(a_fill_bounded, fill_q <= CNT_W'(WINDOW_SIZE), "fill count beyond window size")
  `BTMF_ASSERT(a_load_shows_word, cmd_i.out_load |=> out_valid_o, "loaded result not presented")

endmodule
`default_nettype wire

// File: tb/battery_trimmed_mean_filter_top_tb.sv
`timescale 1ns / 1ps
module battery_trimmed_mean_filter_top_tb;
  import btmf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_SAMPLES = 257;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic            flag;
  } reading_t;

  class filter_scoreboard;
    logic [MV_W-1:0] window_mv [DEF_WINDOW_SIZE];
    int unsigned     held;
    logic [MV_W-1:0] low_mv;
    logic [MV_W-1:0] high_mv;
    reading_t        expected_q [$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     flagged;

    function new();
      foreach (window_mv[i]) window_mv[i] = '0;
      held = 0;
      low_mv = LOW_RESET;
      high_mv = HIGH_RESET;
      errors = 0;
      checked = 0;
      flagged = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] data);
      case (idx)
        REG_LOW_LIMIT: low_mv = data;
        REG_HIGH_LIMIT: high_mv = data;
        default: ;
      endcase
    endfunction

    function void note_sample(logic [RAW_W-1:0] raw);
      logic [PROD_W-1:0] prod;
      logic [MV_W-1:0]   lo;
      logic [MV_W-1:0]   hi;
      int unsigned       total;
      reading_t          want;
      prod = raw;
      prod = prod * SCALE_NUM;
      if (held == DEF_WINDOW_SIZE) begin
        for (int i = 0; i < DEF_WINDOW_SIZE - 1; i++) window_mv[i] = window_mv[i+1];
        window_mv[DEF_WINDOW_SIZE-1] = prod[SCALE_SHIFT +: MV_W];
      end else begin
        window_mv[held] = prod[SCALE_SHIFT +: MV_W];
        held++;
      end
      if (held < MIN_TRIM_COUNT) begin
        want.mv = window_mv[held-1];
      end else begin
        total = 0;
        lo = window_mv[0];
        hi = '0;
        for (int i = 0; i < held; i++) begin
          total += window_mv[i];
          if (window_mv[i] < lo) lo = window_mv[i];
          if (window_mv[i] > hi) hi = window_mv[i];
        end
        total = (total - lo - hi) / (held - 2);
        want.mv = total[MV_W-1:0];
      end
      want.flag = (want.mv > low_mv) && (want.mv < high_mv);
      expected_q.push_back(want);
    endfunction

    task report(string what);
      $display("[%0t] filter error: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [MV_W-1:0] mv, logic flag);
      reading_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word voltage=%0d in_range=%0b", mv, flag));
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (flag === 1'b1) flagged++;
        if (mv !== want.mv) begin
          report($sformatf("voltage_mv got %0d want %0d", mv, want.mv));
        end
        if (flag !== want.flag) begin
          report($sformatf("in_range got %0b want %0b at %0d mV (limits %0d..%0d)",
                           flag, want.flag, want.mv, low_mv, high_mv));
        end
      end
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [RAW_W-1:0]     raw_sample_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [MV_W-1:0]      voltage_mv_o;
  logic                 in_range_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [MV_W-1:0]      cfg_data_i;

  filter_scoreboard sb = new();
  bit               calm;
  int unsigned      samples_sent;
  int unsigned      reg_writes;
  int unsigned      cycle_cnt;

  battery_trimmed_mean_filter_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .voltage_mv_o (voltage_mv_o),
    .in_range_o   (in_range_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycle_cnt,
               sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [RAW_W-1:0] raw_for_mv(int unsigned mv);
    int unsigned r;
    r = (mv * 4096 + 10799) / 10800;
    if (r > 4095) r = 4095;
    return r[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] center);
    int v;
    case ($urandom_range(0, 5))
      0, 1: return RAW_W'($urandom_range(0, 4095));
      2, 3: begin
        v = int'(center) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return RAW_W'(v);
      end
      4: return ($urandom_range(0, 1) != 0) ? RAW_W'(4095) : RAW_W'(0);
      default: return center;
    endcase
  endfunction

  task automatic send_sample(input logic [RAW_W-1:0] raw);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    raw_sample_i <= raw;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(raw);
    samples_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(idx, data);
    reg_writes++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        @(negedge clk_i) out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(voltage_mv_o, in_range_o);
    end
  end

  initial begin
    logic [RAW_W-1:0] directed [23] = '{
      12'd0, 12'd4095, 12'd1, 12'd4095, 12'd0, 12'd2048,
      12'd1138, 12'd1138, 12'd1138, 12'd1138, 12'd1138, 12'd1137,
      12'd1631, 12'd1631, 12'd1631, 12'd1631, 12'd1631, 12'd1630,
      12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd2
    };
    logic [MV_W-1:0]  low_tab [PHASES] = '{14'd0, 14'd16383, 14'd5000, 14'd5000,
                                           14'd0, 14'd0, 14'd3000};
    logic [MV_W-1:0]  high_tab [PHASES] = '{14'd16383, 14'd0, 14'd5001, 14'd5002,
                                            14'd0, 14'd0, 14'd4300};
    logic [MV_W-1:0]  low_mv;
    logic [MV_W-1:0]  high_mv;
    logic [RAW_W-1:0] center;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    raw_sample_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_LOW_LIMIT;
    cfg_data_i = '0;
    cycle_cnt = 0;
    calm = 1'b0;
    samples_sent = 0;
    reg_writes = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_sample(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      low_mv = low_tab[p];
      high_mv = high_tab[p];
      if (p == 4) begin
        low_mv = MV_W'($urandom_range(0, 8000));
        high_mv = low_mv + MV_W'($urandom_range(1, 3000));
      end else if (p == 5) begin
        low_mv = MV_W'($urandom_range(0, 16383));
        high_mv = MV_W'($urandom_range(0, 16383));
      end
      wait_idle();
      write_reg(REG_LOW_LIMIT, low_mv);
      write_reg(REG_HIGH_LIMIT, high_mv);
      if (p == PHASES - 1) begin
        write_reg(REG_SPARE_A, MV_W'($urandom_range(0, 16383)));
        write_reg(REG_SPARE_B, MV_W'($urandom_range(0, 16383)));
      end
      center = raw_for_mv((int'(low_mv) + int'(high_mv)) / 2);
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_sample(pick_raw(center));
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Covered %0d samples and %0d register writes over %0d limit settings.",
             samples_sent, reg_writes, PHASES + 1);
    $display("Checked %0d filtered words, %0d of them inside the limits.",
             sb.checked, sb.flagged);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
